@@ rtl/core/uue_pkg.sv @@
// Shared types, codes and the 6-bit character encoder for the uuencode line encoder.
package uue_pkg;

  localparam int LINE_BYTES_DEF = 45;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_DATA_END = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_BACKQUOTE = 8'h60;
  localparam logic [7:0] CHAR_OFFSET    = 8'h20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       stream_done;
  } out_item_t;

  // Map a 6-bit value to its printable character; zero becomes a backquote.
  function automatic logic [7:0] enc6(input logic [5:0] v);
    logic [7:0] ch;
    if (v == 6'd0) begin
      ch = CHAR_BACKQUOTE;
    end else begin
      ch = {2'b00, v} + CHAR_OFFSET;
    end
    return ch;
  endfunction

endpackage

@@ rtl/core/uuencode_line_encoder.sv @@
// uuencode line encoder: line store, group sequencer and shared 6-bit encoder.
// A byte that does not close a line gives no output and is only stored. A closing item
// gives its first character, the length, through the output register; one store read
// port (read and capture states per byte) and one encoder emitting one character per
// cycle while the output is not stalled pace the line. The end-of-stream line adds a
// backquote and newline. Synchronous active-low reset empties the line and the output.
module uuencode_line_encoder #(
  parameter int LINE_BYTES = uue_pkg::LINE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  uue_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output uue_pkg::out_item_t out_item
);

  localparam int IW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int CW = $clog2(LINE_BYTES + 1);
  localparam int BW = CW + 1;
  localparam logic [BW-1:0] LB_W = BW'(LINE_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CAP  = 3'd3;
  localparam logic [2:0] S_CH   = 3'd4;
  localparam logic [2:0] S_NL   = 3'd5;
  localparam logic [2:0] S_TQ   = 3'd6;
  localparam logic [2:0] S_TNL  = 3'd7;

  logic [7:0] mem [LINE_BYTES];

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          end_r, end_nxt;
  logic [BW-1:0] base_r, base_nxt;
  logic [1:0]    j_r, j_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [23:0]   grp_r, grp_nxt;
  logic [7:0]    mem_q_r;
  logic          rd_ok_r;
  logic          out_valid_r;
  uue_pkg::out_item_t out_item_r;

  logic          in_accept;
  logic          out_free;
  logic          emit;
  uue_pkg::out_item_t emit_item;
  logic [5:0]    enc_in;
  logic          wr_en;
  logic          rd_en;
  logic [BW-1:0] rd_idx;
  logic          rd_ok;
  logic [BW-1:0] fill_inc;
  logic [BW-1:0] base_step;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign fill_inc  = {1'b0, fill_r} + BW'(1);
  assign base_step = base_r + BW'(3);
  assign rd_idx    = base_r + BW'(j_r);
  assign rd_ok     = rd_idx < {1'b0, count_r};

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    end_nxt   = end_r;
    base_nxt  = base_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    grp_nxt   = grp_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    emit      = 1'b0;
    enc_in    = 6'd0;
    emit_item = '{out_char: uue_pkg::CHAR_NEWLINE, last_of_run: 1'b0, stream_done: 1'b0};

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_item.kind)
            uue_pkg::KIND_DATA, uue_pkg::KIND_DATA_END: begin
              wr_en = 1'b1;
              if (fill_inc >= LB_W || in_item.kind == uue_pkg::KIND_DATA_END) begin
                count_nxt = fill_inc[CW-1:0];
                fill_nxt  = '0;
                end_nxt   = (in_item.kind == uue_pkg::KIND_DATA_END);
                base_nxt  = '0;
                state_nxt = S_LEN;
              end else begin
                fill_nxt = fill_inc[CW-1:0];
              end
            end
            uue_pkg::KIND_END: begin
              if (fill_r != '0) begin
                count_nxt = fill_r;
                fill_nxt  = '0;
                end_nxt   = 1'b1;
                base_nxt  = '0;
                state_nxt = S_LEN;
              end else begin
                state_nxt = S_TQ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LEN: begin
        if (out_free) begin
          emit      = 1'b1;
          enc_in    = 6'(count_r);
          emit_item.out_char = uue_pkg::enc6(enc_in);
          j_nxt     = 2'd0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        // pad a short last group with zero bytes
        grp_nxt = {grp_r[15:0], rd_ok_r ? mem_q_r : 8'h00};
        if (j_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = S_CH;
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = S_RD;
        end
      end
      S_CH: begin
        if (out_free) begin
          emit    = 1'b1;
          enc_in  = grp_r[23:18];
          emit_item.out_char = uue_pkg::enc6(enc_in);
          grp_nxt = {grp_r[17:0], 6'd0};
          k_nxt   = k_r + 2'd1;
          if (k_r == 2'd3) begin
            base_nxt = base_step;
            j_nxt    = 2'd0;
            state_nxt = (base_step < {1'b0, count_r}) ? S_RD : S_NL;
          end
        end
      end
      S_NL: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.last_of_run = !end_r;
          state_nxt = end_r ? S_TQ : S_IDLE;
          end_nxt   = 1'b0;
        end
      end
      S_TQ: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.out_char = uue_pkg::CHAR_BACKQUOTE;
          state_nxt = S_TNL;
        end
      end
      S_TNL: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.last_of_run = 1'b1;
          emit_item.stream_done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[IW-1:0]] <= in_item.data_byte;
    end
    if (rd_en && rd_ok) begin
      mem_q_r <= mem[rd_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      end_r   <= end_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    base_r  <= base_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    grp_r   <= grp_nxt;
    if (rd_en) begin
      rd_ok_r <= rd_ok;
    end
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the uuencode line encoder: directed table, random streams.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int LINE_LEN = uue_pkg::LINE_BYTES_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int PAUSE_CYCLES = 20;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS = 35;

  typedef struct {
    uue_pkg::in_item_t item;
    int                typed;  // -1: take the predictor, else count of hand-typed characters
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  uue_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  uue_pkg::out_item_t out_item;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned mismatches = 0;

  logic [7:0]         line_buf [LINE_LEN];
  int unsigned        line_fill = 0;
  uue_pkg::out_item_t encoded[$];
  uue_pkg::out_item_t chars_due[$];
  uue_pkg::out_item_t typed_chars[$];
  row_t               directed[$];

  uuencode_line_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Encoding predictor: mirrors the line store and the fill count.
  function automatic logic [7:0] char_of(input logic [5:0] v);
    return (v == 6'd0) ? uue_pkg::CHAR_BACKQUOTE : ({2'b00, v} + uue_pkg::CHAR_OFFSET);
  endfunction

  function automatic void put_char(input logic [7:0] ch, input logic done);
    uue_pkg::out_item_t c;
    c.out_char = ch;
    c.last_of_run = 1'b0;
    c.stream_done = done;
    encoded.push_back(c);
  endfunction

  function automatic void flush_line();
    int unsigned i;
    logic [7:0]  a, b, c;
    put_char(char_of(line_fill[5:0]), 1'b0);
    for (i = 0; i < line_fill; i += 3) begin
      // pad a short last group with zero bytes
      a = line_buf[i];
      b = (i + 1 < line_fill) ? line_buf[i + 1] : 8'h00;
      c = (i + 2 < line_fill) ? line_buf[i + 2] : 8'h00;
      put_char(char_of(a[7:2]), 1'b0);
      put_char(char_of({a[1:0], b[7:4]}), 1'b0);
      put_char(char_of({b[3:0], c[7:6]}), 1'b0);
      put_char(char_of(c[5:0]), 1'b0);
    end
    put_char(uue_pkg::CHAR_NEWLINE, 1'b0);
    line_fill = 0;
  endfunction

  function automatic void encode_request(input uue_pkg::in_item_t it);
    encoded.delete();
    if (it.kind == uue_pkg::KIND_DATA || it.kind == uue_pkg::KIND_DATA_END) begin
      line_buf[line_fill] = it.data_byte;
      line_fill++;
      if (line_fill >= LINE_LEN) flush_line();
    end
    if (it.kind == uue_pkg::KIND_DATA_END || it.kind == uue_pkg::KIND_END) begin
      if (line_fill > 0) flush_line();
      put_char(uue_pkg::CHAR_BACKQUOTE, 1'b0);
      put_char(uue_pkg::CHAR_NEWLINE, 1'b1);
    end
    if (encoded.size() > 0) encoded[encoded.size() - 1].last_of_run = 1'b1;
  endfunction

  task automatic send_request(input uue_pkg::in_item_t it, input int typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_request(it);
    if (typed < 0) begin
      foreach (encoded[i]) chars_due.push_back(encoded[i]);
    end else begin
      repeat (typed) chars_due.push_back(typed_chars.pop_front());
    end
  endtask

  task automatic send_stream(input int unsigned n_bytes, input bit close_with_byte,
                             inout int unsigned count);
    uue_pkg::in_item_t it;
    int unsigned       k;
    for (k = 0; k < n_bytes; k++) begin
      // drop an ignored request in now and then
      if ($urandom_range(11) == 0) begin
        it.kind = KIND_UNUSED;
        it.data_byte = 8'($urandom_range(255));
        send_request(it, -1);
      end
      it.kind = (close_with_byte && k == n_bytes - 1) ? uue_pkg::KIND_DATA_END
                                                      : uue_pkg::KIND_DATA;
      it.data_byte = 8'($urandom_range(255));
      send_request(it, -1);
      count++;
    end
    if (!close_with_byte || n_bytes == 0) begin
      it.kind = uue_pkg::KIND_END;
      it.data_byte = 8'($urandom_range(255));
      send_request(it, -1);
      count++;
    end
  endtask

  task automatic pause_until_drained(input int cycles);
    in_valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic add_row(input logic [1:0] kind, input logic [7:0] data, input int typed);
    row_t r;
    r.item.kind = kind;
    r.item.data_byte = data;
    r.typed = typed;
    directed.push_back(r);
  endtask

  task automatic add_char(input logic [7:0] ch, input logic last, input logic done);
    uue_pkg::out_item_t c;
    c.out_char = ch;
    c.last_of_run = last;
    c.stream_done = done;
    typed_chars.push_back(c);
  endtask

  initial begin : receiver
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    uue_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (chars_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected character: out_char=%h last=%b done=%b",
                   out_item.out_char, out_item.last_of_run, out_item.stream_done);
      end else begin
        want = chars_due.pop_front();
        if (out_item.out_char !== want.out_char ||
            out_item.last_of_run !== want.last_of_run ||
            out_item.stream_done !== want.stream_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected char=%h last=%b done=%b, got char=%h last=%b done=%b",
                     want.out_char, want.last_of_run, want.stream_done,
                     out_item.out_char, out_item.last_of_run, out_item.stream_done);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned n;
    int          phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;

    // end of stream on an empty store
    add_row(uue_pkg::KIND_END, 8'hA5, 2);
    add_char(uue_pkg::CHAR_BACKQUOTE, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_NEWLINE, 1'b1, 1'b1);
    add_row(KIND_UNUSED, 8'hFF, 0);
    // one all-ones byte: short group padded with zeros
    add_row(uue_pkg::KIND_DATA_END, 8'hFF, 8);
    add_char(8'h21, 1'b0, 1'b0);
    add_char(8'h5F, 1'b0, 1'b0);
    add_char(8'h50, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_BACKQUOTE, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_BACKQUOTE, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_NEWLINE, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_BACKQUOTE, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_NEWLINE, 1'b1, 1'b1);
    // two zero bytes
    add_row(uue_pkg::KIND_DATA, 8'h00, 0);
    add_row(uue_pkg::KIND_DATA_END, 8'h00, 8);
    add_char(8'h22, 1'b0, 1'b0);
    repeat (4) add_char(uue_pkg::CHAR_BACKQUOTE, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_NEWLINE, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_BACKQUOTE, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_NEWLINE, 1'b1, 1'b1);
    // full group of all-ones bytes
    add_row(uue_pkg::KIND_DATA, 8'hFF, 0);
    add_row(uue_pkg::KIND_DATA, 8'hFF, 0);
    add_row(uue_pkg::KIND_DATA_END, 8'hFF, 8);
    add_char(8'h23, 1'b0, 1'b0);
    repeat (4) add_char(8'h5F, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_NEWLINE, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_BACKQUOTE, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_NEWLINE, 1'b1, 1'b1);
    add_row(uue_pkg::KIND_DATA, 8'h12, -1);
    add_row(uue_pkg::KIND_DATA, 8'h34, -1);
    add_row(uue_pkg::KIND_DATA, 8'h56, -1);
    add_row(uue_pkg::KIND_DATA, 8'h78, -1);
    add_row(uue_pkg::KIND_END, 8'h3C, -1);
    add_row(uue_pkg::KIND_DATA, 8'h01, -1);
    add_row(uue_pkg::KIND_DATA, 8'h80, -1);
    add_row(uue_pkg::KIND_END, 8'hFF, -1);
    add_row(uue_pkg::KIND_DATA, 8'h11, -1);
    add_row(KIND_UNUSED, 8'h22, -1);
    add_row(uue_pkg::KIND_DATA_END, 8'h9E, -1);
    add_row(uue_pkg::KIND_END, 8'h00, 2);
    add_char(uue_pkg::CHAR_BACKQUOTE, 1'b0, 1'b0);
    add_char(uue_pkg::CHAR_NEWLINE, 1'b1, 1'b1);

    send_idle_pct = 12;
    recv_idle_pct = 83;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[r]) send_request(directed[r].item, directed[r].typed);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 12;
        end
        default: begin
          // hold the output off while requests keep coming, so the block backs up
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req++;
        end
      endcase
      sent = 0;
      // a full line closed by its last byte, then the terminating line at once
      if (phase == 0) send_stream(LINE_LEN, 1'b1, sent);
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(3))
          0: n = $urandom_range(5);
          1: n = $urandom_range(LINE_LEN + 5, LINE_LEN - 5);
          2: n = $urandom_range(20);
          default: n = LINE_LEN;
        endcase
        send_stream(n, 1'($urandom_range(1)), sent);
      end
      pause_until_drained(PAUSE_CYCLES);
    end

    pause_until_drained(SETTLE_CYCLES);
    if (mismatches == 0 && chars_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
